// ===== hdl/ba_pkg.sv =====
`default_nettype none
// ============================================================================
// ba_pkg
// Shared types and constants of the buddy allocator.
// ============================================================================
package ba_pkg;

  localparam int TOTAL_LOG2 = 16;
  localparam int MIN_LOG2   = 4;
  localparam int SLOT_W     = TOTAL_LOG2 - MIN_LOG2;
  localparam int NSLOTS     = 1 << SLOT_W;
  localparam int NORDERS    = SLOT_W + 1;
  localparam int TOP_ORDER  = SLOT_W;
  localparam int ORD_W      = 4;
  localparam int LINK_W     = SLOT_W + 1;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NSLOTS);

  localparam logic [0:0] KIND_ALLOC = 1'b0;
  localparam logic [0:0] KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOC   = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_FREED   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  localparam logic [3:0] HEADER_RESET = 4'd9;

  typedef struct packed {
    logic [ORD_W-1:0]  order;
    logic              used;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } slot_t;

  typedef struct packed {
    logic meta;
    logic prev;
    logic next;
  } slot_mask_t;

  localparam slot_t SLOT0_RESET = '{order: ORD_W'(TOP_ORDER), used: 1'b0,
                                    prev: NIL, next: NIL};

endpackage : ba_pkg
`default_nettype wire

// ===== hdl/buddy_allocator.sv =====
`default_nettype none
// ============================================================================
// buddy_allocator
// Binary buddy allocator: a sequencer over a slot metadata memory and the
// per-order free list heads.
// ============================================================================
// An allocate passes through decode, one split pass per order above the wanted
// one, and the pop; a free through decode, the slot check, one merge pass per
// step and the push. A refused allocate ends at decode or at the pop read; a null
// or misaligned free at decode; a free of an idle slot at the slot check.
// One request at a time: busy falls while the done word is out, so the next
// request is taken at the edge that takes the result. Reset is synchronous.
// ============================================================================
module buddy_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request command.
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [15:0] req_size,
  input  wire logic [15:0] free_addr,
  input  wire logic        free_null,
  // Result word.
  output logic             done,
  output logic [1:0]       status,
  output logic [15:0]      address,
  output logic [4:0]       block_log2,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ba_pkg::*;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECODE = 5'd1;
  localparam logic [4:0] S_SP_RD  = 5'd2;
  localparam logic [4:0] S_SP_UNL = 5'd3;
  localparam logic [4:0] S_SP_R   = 5'd4;
  localparam logic [4:0] S_SP_H   = 5'd5;
  localparam logic [4:0] S_SP_L   = 5'd6;
  localparam logic [4:0] S_PP_RD  = 5'd7;
  localparam logic [4:0] S_PP_UNL = 5'd8;
  localparam logic [4:0] S_PP_W   = 5'd9;
  localparam logic [4:0] S_FR_CHK = 5'd10;
  localparam logic [4:0] S_MG_RD  = 5'd11;
  localparam logic [4:0] S_MG_CHK = 5'd12;
  localparam logic [4:0] S_MG_N   = 5'd13;
  localparam logic [4:0] S_MG_B   = 5'd14;
  localparam logic [4:0] S_MG_S   = 5'd15;
  localparam logic [4:0] S_PU_W   = 5'd16;
  localparam logic [4:0] S_PU_H   = 5'd17;

  localparam logic REG_HEADER = 1'b0;

  // Configuration register.
  logic [3:0] header_bytes;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HEADER)) begin
      header_bytes <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_HEADER) ? {28'd0, header_bytes} : 32'd0;

  // Sequencer registers.
  logic [4:0]        st;
  logic [ORD_W-1:0]  o;
  logic [ORD_W-1:0]  want;
  logic [4:0]        k;
  logic [SLOT_W-1:0] s;
  logic [SLOT_W-1:0] b;
  logic [LINK_W-1:0] p_lnk;
  logic [LINK_W-1:0] n_lnk;
  logic [LINK_W-1:0] h_lnk;
  logic              kind_q;
  logic [15:0]       req_q;
  logic [15:0]       faddr_q;
  logic              fnull_q;

  // Slot memory and free list heads.
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  slot_t             rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_mask_t        wr_mask;
  slot_t             wr_data;

  logic [ORD_W-1:0]   hd_idx;
  logic [LINK_W-1:0]  hd;
  logic               hw_en;
  logic [ORD_W-1:0]   hw_idx;
  logic [LINK_W-1:0]  hw_val;
  logic [NORDERS-1:0] nonempty;

  ba_slot_ram u_slot_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (wr_data)
  );

  ba_free_lists u_free_lists (
    .clk      (clk),
    .rst      (rst),
    .rd_order (hd_idx),
    .rd_head  (hd),
    .wr_en    (hw_en),
    .wr_order (hw_idx),
    .wr_head  (hw_val),
    .nonempty (nonempty)
  );

  // Size rounding: smallest power of two of at least the minimum block that
  // holds the request plus its header.
  logic [16:0]      need;
  logic             k_ok;
  logic [4:0]       k_calc;
  logic [ORD_W-1:0] want_calc;
  logic             f_ok;
  logic [ORD_W-1:0] found;

  assign need = {1'b0, req_q} + 17'(header_bytes);

  always_comb begin
    k_ok   = 1'b0;
    k_calc = 5'(MIN_LOG2);
    for (int i = TOTAL_LOG2; i >= MIN_LOG2; i--) begin
      if (need <= (17'(1) << i)) begin
        k_ok   = 1'b1;
        k_calc = 5'(i);
      end
    end
  end

  assign want_calc = ORD_W'(k_calc - 5'(MIN_LOG2));

  // Lowest order at or above the wanted one that has a free block.
  always_comb begin
    f_ok  = 1'b0;
    found = '0;
    for (int j = NORDERS - 1; j >= 0; j--) begin
      if (nonempty[j] && (ORD_W'(j) >= want_calc)) begin
        f_ok  = 1'b1;
        found = ORD_W'(j);
      end
    end
  end

  // Free address to slot.
  logic [15:0]       off;
  logic [SLOT_W-1:0] right;
  logic [SLOT_W-1:0] b_calc;
  logic [SLOT_W-1:0] s_min;
  logic [ORD_W-1:0]  o_dn;
  logic              buddy_avail;

  assign off         = faddr_q - {12'd0, header_bytes};
  assign o_dn        = o - ORD_W'(1);
  assign right       = s | (SLOT_W'(1) << o_dn);
  assign b_calc      = s ^ (SLOT_W'(1) << o);
  assign s_min       = (b < s) ? b : s;
  assign buddy_avail = !rd_data.used && (rd_data.order == o);

  assign busy = (st != S_IDLE);

  // The split steps that push halves look at the list one order down.
  assign hd_idx = ((st == S_SP_R) || (st == S_SP_L)) ? o_dn : o;

  // Memory and head accesses of each step. A read never shares a cycle with
  // a write, so the read data always reflects every earlier write.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_mask = '0;
    wr_data = '{order: o, used: 1'b0, prev: NIL, next: NIL};
    hw_en   = 1'b0;
    hw_idx  = o;
    hw_val  = NIL;
    unique case (st)
      S_DECODE: begin
        rd_en   = (kind_q == KIND_FREE);
        rd_addr = off[15:MIN_LOG2];
      end
      S_SP_RD, S_PP_RD: begin
        rd_en   = 1'b1;
        rd_addr = hd[SLOT_W-1:0];
      end
      S_SP_UNL, S_PP_UNL: begin
        // Pop the head: the next block becomes head and loses its back link.
        hw_en        = 1'b1;
        hw_val       = rd_data.next;
        wr_en        = (rd_data.next != NIL);
        wr_addr      = rd_data.next[SLOT_W-1:0];
        wr_mask.prev = 1'b1;
      end
      S_SP_R: begin
        wr_en   = 1'b1;
        wr_addr = right;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: o_dn, used: 1'b0, prev: {1'b0, s}, next: hd};
      end
      S_SP_H: begin
        wr_en        = (h_lnk != NIL);
        wr_addr      = h_lnk[SLOT_W-1:0];
        wr_mask.prev = 1'b1;
        wr_data.prev = {1'b0, right};
      end
      S_SP_L: begin
        wr_en   = 1'b1;
        wr_addr = s;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: o_dn, used: 1'b0, prev: NIL, next: {1'b0, right}};
        hw_en   = 1'b1;
        hw_idx  = o_dn;
        hw_val  = {1'b0, s};
      end
      S_PP_W: begin
        wr_en   = 1'b1;
        wr_addr = s;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: o, used: 1'b1, prev: NIL, next: NIL};
      end
      S_FR_CHK: begin
        wr_en   = rd_data.used && (rd_data.order < ORD_W'(NORDERS));
        wr_addr = s;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: rd_data.order, used: 1'b0, prev: NIL, next: NIL};
      end
      S_MG_RD: begin
        rd_en   = (o != ORD_W'(TOP_ORDER));
        rd_addr = b_calc;
      end
      S_MG_CHK: begin
        // Unlink the buddy from its list.
        if (buddy_avail) begin
          if (rd_data.prev != NIL) begin
            wr_en        = 1'b1;
            wr_addr      = rd_data.prev[SLOT_W-1:0];
            wr_mask.next = 1'b1;
            wr_data.next = rd_data.next;
          end else begin
            hw_en  = 1'b1;
            hw_val = rd_data.next;
          end
        end
      end
      S_MG_N: begin
        wr_en        = (n_lnk != NIL);
        wr_addr      = n_lnk[SLOT_W-1:0];
        wr_mask.prev = 1'b1;
        wr_data.prev = p_lnk;
      end
      S_MG_B: begin
        wr_en   = 1'b1;
        wr_addr = b;
        wr_mask = '{meta: 1'b0, prev: 1'b1, next: 1'b1};
      end
      S_MG_S: begin
        wr_en   = 1'b1;
        wr_addr = s_min;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: o + ORD_W'(1), used: 1'b0, prev: NIL, next: NIL};
      end
      S_PU_W: begin
        wr_en   = 1'b1;
        wr_addr = s;
        wr_mask = '{meta: 1'b1, prev: 1'b1, next: 1'b1};
        wr_data = '{order: o, used: 1'b0, prev: NIL, next: hd};
        hw_en   = 1'b1;
        hw_val  = {1'b0, s};
      end
      S_PU_H: begin
        wr_en        = (h_lnk != NIL);
        wr_addr      = h_lnk[SLOT_W-1:0];
        wr_mask.prev = 1'b1;
        wr_data.prev = {1'b0, s};
      end
      default: begin
      end
    endcase
  end

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            kind_q  <= kind;
            req_q   <= req_size;
            faddr_q <= free_addr;
            fnull_q <= free_null;
            st      <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (kind_q == KIND_ALLOC) begin
            if (!k_ok || !f_ok) begin
              done       <= 1'b1;
              status     <= STAT_NOFIT;
              address    <= '0;
              block_log2 <= '0;
              st         <= S_IDLE;
            end else begin
              k    <= k_calc;
              want <= want_calc;
              o    <= found;
              st   <= (found > want_calc) ? S_SP_RD : S_PP_RD;
            end
          end else if (fnull_q || (off[MIN_LOG2-1:0] != '0)) begin
            done       <= 1'b1;
            status     <= STAT_IGNORED;
            address    <= '0;
            block_log2 <= '0;
            st         <= S_IDLE;
          end else begin
            s  <= off[15:MIN_LOG2];
            st <= S_FR_CHK;
          end
        end
        S_SP_RD: begin
          s  <= hd[SLOT_W-1:0];
          st <= S_SP_UNL;
        end
        S_SP_UNL: st <= S_SP_R;
        S_SP_R: begin
          h_lnk <= hd;
          st    <= S_SP_H;
        end
        S_SP_H: st <= S_SP_L;
        S_SP_L: begin
          o  <= o_dn;
          st <= (o_dn > want) ? S_SP_RD : S_PP_RD;
        end
        S_PP_RD: begin
          if (hd == NIL) begin
            done       <= 1'b1;
            status     <= STAT_NOFIT;
            address    <= '0;
            block_log2 <= '0;
            st         <= S_IDLE;
          end else begin
            s  <= hd[SLOT_W-1:0];
            st <= S_PP_UNL;
          end
        end
        S_PP_UNL: st <= S_PP_W;
        S_PP_W: begin
          done       <= 1'b1;
          status     <= STAT_ALLOC;
          address    <= {s, {MIN_LOG2{1'b0}}} + 16'(header_bytes);
          block_log2 <= k;
          st         <= S_IDLE;
        end
        S_FR_CHK: begin
          // A slot not in use means a double free or an interior address.
          if (!rd_data.used || (rd_data.order >= ORD_W'(NORDERS))) begin
            done       <= 1'b1;
            status     <= STAT_IGNORED;
            address    <= '0;
            block_log2 <= '0;
            st         <= S_IDLE;
          end else begin
            o  <= rd_data.order;
            st <= S_MG_RD;
          end
        end
        S_MG_RD: begin
          if (o == ORD_W'(TOP_ORDER)) begin
            st <= S_PU_W;
          end else begin
            b  <= b_calc;
            st <= S_MG_CHK;
          end
        end
        S_MG_CHK: begin
          if (!buddy_avail) begin
            st <= S_PU_W;
          end else begin
            p_lnk <= rd_data.prev;
            n_lnk <= rd_data.next;
            st    <= S_MG_N;
          end
        end
        S_MG_N: st <= S_MG_B;
        S_MG_B: st <= S_MG_S;
        S_MG_S: begin
          s  <= s_min;
          o  <= o + ORD_W'(1);
          st <= S_MG_RD;
        end
        S_PU_W: begin
          h_lnk <= hd;
          st    <= S_PU_H;
        end
        S_PU_H: begin
          done       <= 1'b1;
          status     <= STAT_FREED;
          address    <= {s, {MIN_LOG2{1'b0}}};
          block_log2 <= 5'(o) + 5'(MIN_LOG2);
          st         <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule : buddy_allocator
`default_nettype wire

// ===== hdl/ba_slot_ram.sv =====
`default_nettype none
// ============================================================================
// ba_slot_ram
// Per-slot metadata memory with field write enables and registered read.
// ============================================================================
module ba_slot_ram (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [ba_pkg::SLOT_W-1:0]  rd_addr,
  output ba_pkg::slot_t                   rd_data,
  input  wire logic                       wr_en,
  input  wire logic [ba_pkg::SLOT_W-1:0]  wr_addr,
  input  wire ba_pkg::slot_mask_t         wr_mask,
  input  wire ba_pkg::slot_t              wr_data
);
  import ba_pkg::*;

  slot_t mem [NSLOTS];
  slot_t rd_q;
  logic  rd_init;
  // Slot 0 holds the whole region after reset until it is first written.
  logic  init0;
  logic  init_hit;

  assign init_hit = init0 && (wr_addr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      init0 <= 1'b1;
    end else if (wr_en && init_hit) begin
      init0 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.meta || init_hit) begin
        mem[wr_addr].order <= wr_mask.meta ? wr_data.order : SLOT0_RESET.order;
        mem[wr_addr].used  <= wr_mask.meta ? wr_data.used  : SLOT0_RESET.used;
      end
      if (wr_mask.prev || init_hit) begin
        mem[wr_addr].prev <= wr_mask.prev ? wr_data.prev : SLOT0_RESET.prev;
      end
      if (wr_mask.next || init_hit) begin
        mem[wr_addr].next <= wr_mask.next ? wr_data.next : SLOT0_RESET.next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_init <= init0 && (rd_addr == '0);
    end
  end

  assign rd_data = rd_init ? SLOT0_RESET : rd_q;

endmodule : ba_slot_ram
`default_nettype wire

// ===== hdl/ba_free_lists.sv =====
`default_nettype none
// ============================================================================
// ba_free_lists
// Head pointers of the per-order free lists and the nonempty mask.
// ============================================================================
module ba_free_lists (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ba_pkg::ORD_W-1:0]   rd_order,
  output logic [ba_pkg::LINK_W-1:0]       rd_head,
  input  wire logic                       wr_en,
  input  wire logic [ba_pkg::ORD_W-1:0]   wr_order,
  input  wire logic [ba_pkg::LINK_W-1:0]  wr_head,
  output logic [ba_pkg::NORDERS-1:0]      nonempty
);
  import ba_pkg::*;

  logic [LINK_W-1:0] head [NORDERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORDERS; i++) begin
        head[i] <= (i == TOP_ORDER) ? '0 : NIL;
      end
    end else if (wr_en && (wr_order < ORD_W'(NORDERS))) begin
      head[wr_order] <= wr_head;
    end
  end

  assign rd_head = (rd_order < ORD_W'(NORDERS)) ? head[rd_order] : NIL;

  always_comb begin
    for (int i = 0; i < NORDERS; i++) begin
      nonempty[i] = (head[i] != NIL);
    end
  end

endmodule : ba_free_lists
`default_nettype wire

// ===== bench/ba_checker.sv =====
// ============================================================================
// ba_checker
// Watches the request, result and configuration channels of the buddy
// allocator. It keeps its own copy of the free lists and slot metadata,
// predicts the result word of every accepted request and compares it.
// ============================================================================
module ba_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        kind,
  input  wire logic [15:0] req_size,
  input  wire logic [15:0] free_addr,
  input  wire logic        free_null,
  input  wire logic        done,
  input  wire logic [1:0]  status,
  input  wire logic [15:0] address,
  input  wire logic [4:0]  block_log2,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               outstanding
);
  import ba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_HEADER = 3'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
    logic [4:0]  block_log2;
  } alloc_word_t;

  logic [3:0] hdr_bytes;
  int unsigned head_of[NORDERS];
  int unsigned count_of[NORDERS];
  logic [ORD_W-1:0] order_of[NSLOTS];
  logic used_of[NSLOTS];
  int unsigned prev_of[NSLOTS];
  int unsigned next_of[NSLOTS];
  alloc_word_t pending_words[$];

  function automatic void push_free(int unsigned s, int unsigned o);
    int unsigned h;
    h = head_of[o];
    next_of[s] = h;
    prev_of[s] = NSLOTS;
    if (h < NSLOTS) prev_of[h] = s;
    head_of[o] = s;
    count_of[o] = (count_of[o] + 1) & 13'h1fff;
  endfunction

  function automatic void unlink_free(int unsigned s);
    int unsigned o, p, n;
    o = order_of[s];
    p = prev_of[s];
    n = next_of[s];
    if (o >= NORDERS) return;
    if (p < NSLOTS) next_of[p] = n;
    else head_of[o] = n;
    if (n < NSLOTS) prev_of[n] = p;
    prev_of[s] = NSLOTS;
    next_of[s] = NSLOTS;
    count_of[o] = (count_of[o] - 1) & 13'h1fff;
  endfunction

  function automatic void clear_heap();
    for (int i = 0; i < NORDERS; i++) begin
      head_of[i] = NSLOTS;
      count_of[i] = 0;
    end
    for (int i = 0; i < NSLOTS; i++) begin
      order_of[i] = '0;
      used_of[i] = 1'b0;
      prev_of[i] = NSLOTS;
      next_of[i] = NSLOTS;
    end
    order_of[0] = ORD_W'(TOP_ORDER);
    push_free(0, TOP_ORDER);
  endfunction

  // Applies one request to the model and returns the word it should produce.
  function automatic alloc_word_t serve_request(logic k_in, logic [15:0] sz,
                                                logic [15:0] fa, logic fn);
    alloc_word_t w;
    int unsigned need, k, want, found, left, right, s, o, b, off;
    w = '{status: STAT_IGNORED, address: '0, block_log2: '0};
    if (k_in == KIND_ALLOC) begin
      need = sz + hdr_bytes;
      k = MIN_LOG2;
      while (k < 31 && (32'd1 << k) < need) k++;
      w.status = STAT_NOFIT;
      if (k > TOTAL_LOG2) return w;
      want = k - MIN_LOG2;
      found = want;
      while (found < NORDERS && count_of[found] == 0) found++;
      if (found >= NORDERS || head_of[found] >= NSLOTS) return w;
      // Split heads down to the wanted order: right half first, then left.
      for (o = found; o > want; o--) begin
        left = head_of[o];
        right = left + (1 << (o - 1));
        unlink_free(left);
        order_of[left] = ORD_W'(o - 1);
        used_of[left] = 1'b0;
        if (right < NSLOTS) begin
          order_of[right] = ORD_W'(o - 1);
          used_of[right] = 1'b0;
          push_free(right, o - 1);
        end
        push_free(left, o - 1);
      end
      s = head_of[want];
      if (s >= NSLOTS) return w;
      unlink_free(s);
      order_of[s] = ORD_W'(want);
      used_of[s] = 1'b1;
      w.status = STAT_ALLOC;
      w.address = 16'((s << MIN_LOG2) + hdr_bytes);
      w.block_log2 = 5'(k);
    end else begin
      if (fn) return w;
      off = (fa - hdr_bytes) & 16'hffff;
      if ((off & ((1 << MIN_LOG2) - 1)) != 0) return w;
      s = off >> MIN_LOG2;
      if (s >= NSLOTS || !used_of[s] || order_of[s] >= NORDERS) return w;
      o = order_of[s];
      used_of[s] = 1'b0;
      prev_of[s] = NSLOTS;
      next_of[s] = NSLOTS;
      // Merge with the buddy while it is free and of the same order.
      while (o < TOP_ORDER) begin
        b = s ^ (1 << o);
        if (b >= NSLOTS || used_of[b] || order_of[b] != o) break;
        unlink_free(b);
        if (b < s) s = b;
        o++;
        order_of[s] = ORD_W'(o);
        used_of[s] = 1'b0;
        prev_of[s] = NSLOTS;
        next_of[s] = NSLOTS;
      end
      push_free(s, o);
      w.status = STAT_FREED;
      w.address = 16'(s << MIN_LOG2);
      w.block_log2 = 5'(o + MIN_LOG2);
    end
    return w;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    alloc_word_t want_w;
    if (rst) begin
      hdr_bytes = HEADER_RESET;
      clear_heap();
      pending_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_HEADER[2])
        hdr_bytes = pwdata[3:0];
      // Results are compared before the same edge's request is queued.
      if (done) begin
        if (pending_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with nothing expected: st=%0d addr=%0d log2=%0d",
                     $realtime, status, address, block_log2);
        end else begin
          want_w = pending_words.pop_front();
          if (want_w != {status, address, block_log2}) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp st=%0d addr=%0d log2=%0d",
                        " got st=%0d addr=%0d log2=%0d"},
                       $realtime, want_w.status, want_w.address, want_w.block_log2,
                       status, address, block_log2);
          end
        end
      end
      if (start && !busy)
        pending_words.push_back(serve_request(kind, req_size, free_addr, free_null));
    end
    outstanding = pending_words.size();
  end

endmodule

// ===== bench/tb_buddy_allocator.sv =====
// ============================================================================
// tb_buddy_allocator
// Drives allocate and free requests into the buddy allocator with random
// gaps, over several header sizes, and lets the checker judge every word.
// ============================================================================
module tb_buddy_allocator;
  import ba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        kind;
  logic [15:0] req_size;
  logic [15:0] free_addr;
  logic        free_null;
  logic        done;
  logic [1:0]  status;
  logic [15:0] address;
  logic [4:0]  block_log2;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;

  // The header size that the stimulus currently believes is programmed.
  logic [3:0]  cur_hdr;
  // Usable addresses of blocks granted and not yet freed, and of blocks
  // already released (for double-free attempts within a phase).
  logic [15:0] live_blocks[$];
  logic [15:0] released[$];
  int          idle_cycles;

  buddy_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .req_size(req_size), .free_addr(free_addr), .free_null(free_null),
    .done(done), .status(status), .address(address), .block_log2(block_log2),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ba_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .req_size(req_size), .free_addr(free_addr), .free_null(free_null),
    .done(done), .status(status), .address(address), .block_log2(block_log2),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every granted block becomes a candidate for a later free.
  always @(posedge clk) begin
    if (!rst && done && status == STAT_ALLOC) live_blocks.push_back(address);
  end

  // The watchdog counts cycles in which neither a request nor a result word
  // moves; a hung sequencer ends the run here.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Sends one request word after a random gap and returns at the edge that
  // accepted it. Start stays high when the next word follows with no gap.
  task automatic send_word(logic k_in, logic [15:0] sz, logic [15:0] fa, logic fn);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k_in;
    req_size <= sz;
    free_addr <= fa;
    free_null <= fn;
    // Busy is stable at the falling edge; once low, the next edge accepts.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_alloc(logic [15:0] sz);
    send_word(KIND_ALLOC, sz, 16'($urandom), 1'($urandom));
  endtask

  // Frees a randomly chosen live block.
  task automatic free_live();
    int idx;
    logic [15:0] a;
    idx = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[idx];
    live_blocks.delete(idx);
    released.push_back(a);
    if (released.size() > 64) void'(released.pop_front());
    send_word(KIND_FREE, 16'($urandom), a, 1'b0);
  endtask

  // A misaligned address is refused without its slot being checked.
  task automatic free_misaligned(logic [15:0] a);
    if (((a - cur_hdr) & 16'hf) == 0) a = a ^ 16'h1;
    send_word(KIND_FREE, 16'($urandom), a, 1'b0);
  endtask

  // Waits until every expected word has come and the block is idle again.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic release_all();
    while (live_blocks.size() > 0) free_live();
    drain();
    while (live_blocks.size() > 0) free_live();
    drain();
    released.delete();
  endtask

  task automatic write_header(logic [3:0] h);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {28'($urandom), h};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    cur_hdr = h;
  endtask

  task automatic random_items(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || (pick < 86 && live_blocks.size() == 0))
        send_alloc(16'($urandom_range(0, 120)));
      else if (pick < 45)
        send_alloc(16'($urandom));
      else if (pick < 50)
        send_alloc(16'($urandom_range(0, 4096)));
      else if (pick < 86)
        free_live();
      else if (pick < 91)
        send_word(KIND_FREE, 16'($urandom), 16'($urandom), 1'b1);
      else if (pick < 95)
        free_misaligned(16'($urandom));
      else if (released.size() > 0)
        send_word(KIND_FREE, 16'($urandom),
                  released[$urandom_range(0, released.size() - 1)], 1'b0);
      else
        send_alloc(16'($urandom_range(0, 60)));
      // Sometimes let the sender hold off until the allocator has caught up.
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    logic [3:0] hdr_plan[5];
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_ALLOC;
    req_size = '0;
    free_addr = '0;
    free_null = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_hdr = HEADER_RESET;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset header: the whole region in one grant,
    // no fit while it is held, its free, a double free, a null free, a
    // misaligned free, the deepest split chain and a too-large request.
    send_alloc(16'(65536 - HEADER_RESET));
    send_alloc(16'd0);
    send_word(KIND_FREE, 16'hffff, 16'(HEADER_RESET), 1'b0);
    send_word(KIND_FREE, 16'h0000, 16'(HEADER_RESET), 1'b0);
    send_word(KIND_FREE, 16'hffff, 16'hffff, 1'b1);
    free_misaligned(16'd10);
    send_alloc(16'd0);
    send_alloc(16'd7);
    send_alloc(16'd8);
    send_alloc(16'd100);
    send_alloc(16'd1000);
    send_alloc(16'd30000);
    send_alloc(16'hffff);
    send_alloc(16'd32760);
    drain();
    release_all();

    // Each phase programs a header size and then runs random traffic.
    hdr_plan = '{4'd0, 4'd15, 4'($urandom), HEADER_RESET, 4'($urandom)};
    foreach (hdr_plan[p]) begin
      write_header(hdr_plan[p]);
      send_alloc(16'(16 - hdr_plan[p]));
      send_alloc(16'(17 - hdr_plan[p]));
      send_alloc(16'(65536 - hdr_plan[p]));
      random_items(200);
      drain();
      release_all();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
